[sv/wmb_pkg.sv]
// shared types and constants for the waveform min/max/rms binner
package wmb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 24;
  localparam int COLS_W   = 13;
  localparam int COL_W    = 12;
  localparam int POS_W    = TOTAL_W + COLS_W;
  localparam int SUM_W    = 55;
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int PROD_W   = SUM_W + COLS_W;
  localparam int QUO_W    = 2 * (SAMPLE_W - 1);
  localparam int ROOT_W   = QUO_W + 1;
  localparam int RMS_W    = 16;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 24'd1048576;
  localparam logic [COLS_W-1:0]  COLS_RST  = 13'd1024;
  localparam logic [COLS_W-1:0]  COLS_MAX  = 13'd4096;
  localparam logic [RMS_W-1:0]   RMS_SAT   = 16'h8000;

  localparam logic [IDX_W-1:0] REG_TOTAL   = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd1;

  localparam logic [CNT_W-1:0] MUL_LAST  = 7'd12;
  localparam logic [CNT_W-1:0] DIV_LAST  = 7'd67;
  localparam logic [CNT_W-1:0] SQRT_LAST = 7'd14;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_RMS,
    ST_OUT
  } st_t;

  typedef enum logic [2:0] {
    RU_IDLE,
    RU_MUL,
    RU_DIV,
    RU_SQRT,
    RU_DONE
  } ru_ph_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] total;
    logic [COLS_W-1:0]  columns;
  } rms_req_t;

  typedef struct packed {
    logic             done;
    logic [RMS_W-1:0] rms;
  } rms_rsp_t;

endpackage

[sv/wmb_rms_unit.sv]
// iterative rms unit: shift-add multiply, restoring divide and square root on one adder
module wmb_rms_unit
  import wmb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rms_req_t req,
  output rms_rsp_t rsp
);

  ru_ph_t              ph_r, ph_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]    mcand_r, mcand_nxt;
  logic [COLS_W-1:0]   mplier_r, mplier_nxt;
  logic [TOTAL_W-1:0]  div_r, div_nxt;
  logic [TOTAL_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic                ovf_r, ovf_nxt;
  logic [QUO_W-1:0]    v_r, v_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [RMS_W-1:0]    rms_r, rms_nxt;

  // shared adder
  logic [PROD_W-1:0]   add_a, add_b;
  logic                add_sub;
  logic [PROD_W:0]     add_res;
  logic                add_neg;

  logic [TOTAL_W:0]    rem_sh;
  logic [ROOT_W-1:0]   bit_v;
  logic [ROOT_W-1:0]   rb;

  assign rem_sh  = {rem_r, acc_r[PROD_W-1]};
  assign bit_v   = ROOT_W'(1) << {cnt_r[3:0], 1'b0};
  assign rb      = root_r + bit_v;
  assign add_res = {1'b0, add_a} + ({1'b0, add_b} ^ {(PROD_W+1){add_sub}})
                   + (PROD_W+1)'(add_sub);
  assign add_neg = add_res[PROD_W];

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (ph_r)
      RU_MUL: begin
        add_a = {acc_r[PROD_W-2:0], 1'b0};
        add_b = mplier_r[cnt_r[3:0]] ? PROD_W'(mcand_r) : '0;
      end
      RU_DIV: begin
        add_a   = PROD_W'(rem_sh);
        add_b   = PROD_W'(div_r);
        add_sub = 1'b1;
      end
      RU_SQRT: begin
        add_a   = PROD_W'(v_r);
        add_b   = PROD_W'(rb);
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    ovf_nxt    = ovf_r;
    v_nxt      = v_r;
    root_nxt   = root_r;
    rms_nxt    = rms_r;
    unique case (ph_r)
      RU_IDLE: begin
        if (req.start) begin
          acc_nxt    = '0;
          mcand_nxt  = req.sum;
          mplier_nxt = req.columns;
          div_nxt    = req.total;
          cnt_nxt    = MUL_LAST;
          ph_nxt     = RU_MUL;
        end
      end
      RU_MUL: begin
        acc_nxt = add_res[PROD_W-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          cnt_nxt = DIV_LAST;
          rem_nxt = '0;
          quo_nxt = '0;
          ovf_nxt = 1'b0;
          ph_nxt  = RU_DIV;
        end
      end
      RU_DIV: begin
        acc_nxt = {acc_r[PROD_W-2:0], 1'b0};
        rem_nxt = add_neg ? rem_sh[TOTAL_W-1:0] : add_res[TOTAL_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], ~add_neg};
        ovf_nxt = ovf_r | quo_r[QUO_W-1];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (ovf_nxt) begin
            rms_nxt = RMS_SAT;
            ph_nxt  = RU_DONE;
          end else begin
            v_nxt    = quo_nxt;
            root_nxt = '0;
            cnt_nxt  = SQRT_LAST;
            ph_nxt   = RU_SQRT;
          end
        end
      end
      RU_SQRT: begin
        if (add_neg) begin
          root_nxt = root_r >> 1;
        end else begin
          v_nxt    = add_res[QUO_W-1:0];
          root_nxt = (root_r >> 1) + bit_v;
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          rms_nxt = root_nxt[RMS_W-1:0];
          ph_nxt  = RU_DONE;
        end
      end
      RU_DONE: begin
        ph_nxt = RU_IDLE;
      end
      default: begin
        ph_nxt = RU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= RU_IDLE;
      cnt_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    ovf_r    <= ovf_nxt;
    v_r      <= v_nxt;
    root_r   <= root_nxt;
    rms_r    <= rms_nxt;
  end

  assign rsp.done = (ph_r == RU_DONE);
  assign rsp.rms  = rms_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> ph_r == RU_IDLE)
    else $error("rms unit started while busy");

  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == RU_MUL && cnt_r == '0) |=> (ph_r == RU_DIV && cnt_r == DIV_LAST))
    else $error("multiply did not hand over to divide");

  a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == RU_SQRT |-> cnt_r <= SQRT_LAST)
    else $error("square root step count out of range");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == RU_DONE |=> ph_r == RU_IDLE)
    else $error("done held longer than one cycle");

endmodule

[sv/waveform_min_max_rms_binner_top.sv]
// top level of the waveform min/max/rms binner: bin tracking, sequencer and output register
//
// in_* carries one Q1.15 sample per transaction; in_first_of_clip restarts
// binning at column 0. cfg_* writes total_samples (index 0) and
// column_count (index 1); cfg_ready is always high, write only while idle.
// out_* carries one transaction per closed column: min, max, rms and a
// last-column flag.
// a sample that closes no column holds off the next one: in_ready drops
// for the one bin-update cycle after acceptance.
// a sample that closes a column runs the shared rms unit: 13 multiply
// steps, 68 divide steps and up to 15 square-root steps on one adder,
// after which the result goes to the output register.
// the output register holds a result while out_ready is low; samples that
// close no column are still taken meanwhile, and a closing sample waits
// with its result until the register frees.
// reset (synchronous, rst_n low) loads the default configuration and
// starts a new clip at column 0; no clearing pass is needed.
module waveform_min_max_rms_binner_top
  import wmb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_first_of_clip,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COL_W-1:0]           out_column,
  output logic signed [SAMPLE_W-1:0] out_min_value,
  output logic signed [SAMPLE_W-1:0] out_max_value,
  output logic [RMS_W-1:0]           out_rms_value,
  output logic                       out_last_column,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [TOTAL_W-1:0]         cfg_wdata
);

  st_t                        state_r, state_nxt;
  logic [TOTAL_W-1:0]         cfg_total_r, cfg_total_nxt;
  logic [COLS_W-1:0]          cfg_cols_r, cfg_cols_nxt;
  logic [POS_W-1:0]           end_r, end_nxt;

  logic [COL_W-1:0]           col_r, col_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [POS_W-1:0]           bnd_r, bnd_nxt;
  logic                       open_r, open_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;

  logic signed [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;

  logic [COL_W-1:0]           hcol_r, hcol_nxt;
  logic signed [SAMPLE_W-1:0] hmin_r, hmin_nxt;
  logic signed [SAMPLE_W-1:0] hmax_r, hmax_nxt;
  logic                       hlast_r, hlast_nxt;
  logic [RMS_W-1:0]           hrms_r, hrms_nxt;

  logic                       ov_r, ov_nxt;
  logic [COL_W-1:0]           ocol_r, ocol_nxt;
  logic signed [SAMPLE_W-1:0] omin_r, omin_nxt;
  logic signed [SAMPLE_W-1:0] omax_r, omax_nxt;
  logic [RMS_W-1:0]           orms_r, orms_nxt;
  logic                       olast_r, olast_nxt;

  logic [TOTAL_W-1:0]         t_eff;
  logic [COLS_W-1:0]          c_sat;
  logic [COLS_W-1:0]          c_eff;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  logic                       step_past;
  logic                       step_close;
  logic                       step_last;
  logic [POS_W-1:0]           pos_step;
  logic signed [SAMPLE_W-1:0] upd_min, upd_max;
  logic [SUM_W:0]             sum_add;
  logic [SUM_W-1:0]           upd_sum;
  logic                       accept;

  rms_req_t req;
  rms_rsp_t rsp;

  wmb_rms_unit u_rms (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // effective configuration
  assign t_eff   = (cfg_total_r == '0) ? TOTAL_W'(1) : cfg_total_r;
  assign c_sat   = (cfg_cols_r == '0) ? COLS_W'(1) :
                   (cfg_cols_r > COLS_MAX) ? COLS_MAX : cfg_cols_r;
  assign c_eff   = (TOTAL_W'(c_sat) > t_eff) ? t_eff[COLS_W-1:0] : c_sat;
  assign end_nxt = {{COLS_W{1'b0}}, t_eff} * {{TOTAL_W{1'b0}}, c_eff};

  assign sq_full = in_sample * in_sample;
  assign accept  = in_valid && in_ready;

  // bin update for the held sample
  assign step_past  = (pos_r >= end_r) || ({1'b0, col_r} >= c_eff);
  assign upd_min    = (!open_r || smp_r < min_r) ? smp_r : min_r;
  assign upd_max    = (!open_r || smp_r > max_r) ? smp_r : max_r;
  assign sum_add    = {1'b0, sum_r} + (SUM_W+1)'(sq_r);
  assign upd_sum    = !open_r ? SUM_W'(sq_r) :
                      sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign pos_step   = pos_r + POS_W'(c_eff);
  assign step_close = !(pos_step < bnd_r);
  assign step_last  = ({1'b0, col_r} == (c_eff - COLS_W'(1)));

  always_comb begin
    state_nxt     = state_r;
    cfg_total_nxt = cfg_total_r;
    cfg_cols_nxt  = cfg_cols_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    bnd_nxt       = bnd_r;
    open_nxt      = open_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    smp_nxt       = smp_r;
    sq_nxt        = sq_r;
    hcol_nxt      = hcol_r;
    hmin_nxt      = hmin_r;
    hmax_nxt      = hmax_r;
    hlast_nxt     = hlast_r;
    hrms_nxt      = hrms_r;
    ov_nxt        = ov_r && !out_ready;
    ocol_nxt      = ocol_r;
    omin_nxt      = omin_r;
    omax_nxt      = omax_r;
    orms_nxt      = orms_r;
    olast_nxt     = olast_r;
    req.start     = 1'b0;
    req.sum       = upd_sum;
    req.total     = t_eff;
    req.columns   = c_eff;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOTAL:   cfg_total_nxt = cfg_wdata;
        REG_COLUMNS: cfg_cols_nxt  = cfg_wdata[COLS_W-1:0];
        default:     cfg_total_nxt = cfg_total_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          smp_nxt = in_sample;
          sq_nxt  = sq_full[SQ_W-1:0];
          if (in_first_of_clip) begin
            col_nxt  = '0;
            pos_nxt  = '0;
            bnd_nxt  = POS_W'(t_eff);
            open_nxt = 1'b0;
          end
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        state_nxt = ST_IDLE;
        if (!step_past) begin
          min_nxt  = upd_min;
          max_nxt  = upd_max;
          sum_nxt  = upd_sum;
          open_nxt = 1'b1;
          if (!step_close) begin
            pos_nxt = pos_step;
          end else begin
            hcol_nxt  = col_r;
            hmin_nxt  = upd_min;
            hmax_nxt  = upd_max;
            hlast_nxt = step_last;
            req.start = 1'b1;
            state_nxt = ST_RMS;
            if (step_last) begin
              open_nxt = 1'b0;
              pos_nxt  = end_r;
            end else begin
              col_nxt = col_r + COL_W'(1);
              if (pos_step > bnd_r) begin
                min_nxt = smp_r;
                max_nxt = smp_r;
                sum_nxt = SUM_W'(sq_r);
              end else begin
                open_nxt = 1'b0;
              end
              bnd_nxt = bnd_r + POS_W'(t_eff);
              pos_nxt = pos_step;
            end
          end
        end
      end
      ST_RMS: begin
        if (rsp.done) begin
          hrms_nxt  = rsp.rms;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = hcol_r;
          omin_nxt  = hmin_r;
          omax_nxt  = hmax_r;
          orms_nxt  = hrms_r;
          olast_nxt = hlast_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_total_r <= TOTAL_RST;
      cfg_cols_r  <= COLS_RST;
      col_r       <= '0;
      pos_r       <= '0;
      bnd_r       <= POS_W'(TOTAL_RST);
      open_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_total_r <= cfg_total_nxt;
      cfg_cols_r  <= cfg_cols_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      bnd_r       <= bnd_nxt;
      open_r      <= open_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r   <= end_nxt;
    min_r   <= min_nxt;
    max_r   <= max_nxt;
    sum_r   <= sum_nxt;
    smp_r   <= smp_nxt;
    sq_r    <= sq_nxt;
    hcol_r  <= hcol_nxt;
    hmin_r  <= hmin_nxt;
    hmax_r  <= hmax_nxt;
    hlast_r <= hlast_nxt;
    hrms_r  <= hrms_nxt;
    ocol_r  <= ocol_nxt;
    omin_r  <= omin_nxt;
    omax_r  <= omax_nxt;
    orms_r  <= orms_nxt;
    olast_r <= olast_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_column      = ocol_r;
  assign out_min_value   = omin_r;
  assign out_max_value   = omax_r;
  assign out_rms_value   = orms_r;
  assign out_last_column = olast_r;

  a_done_in_rms: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == ST_RMS)
    else $error("rms result arrived outside the rms wait");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == ST_OUT))
    else $error("output register loaded without a closed column");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && !step_past && step_close && step_last) |=> !open_r)
    else $error("bin left open after the final column");

endmodule

[verif/waveform_min_max_rms_binner_top_tb.sv]
// testbench for the waveform min/max/rms binner: directed table, random clips, column checker
module waveform_min_max_rms_binner_top_tb;
  import wmb_pkg::*;

  localparam int RAND_ITEMS = 1650;
  localparam int QUIET_ITEMS = 200;
  localparam int DRAIN_CYCLES = 120;
  localparam int LONG_HOLD = 300;
  localparam int MAX_SPAN = 200;
  localparam longint unsigned RMS_FULL = 64'd32768;
  localparam longint unsigned POS_MASK = (64'd1 << POS_W) - 64'd1;

  typedef struct packed {
    logic [COL_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic [RMS_W-1:0]           rms;
    logic                       last;
  } bin_result_t;

  typedef enum logic [0:0] {
    ROW_CFG,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [IDX_W-1:0]           idx;
    logic [TOTAL_W-1:0]         data;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
    logic                       typed;
    bin_result_t                expected;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_first_of_clip = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [COL_W-1:0]           out_column;
  logic signed [SAMPLE_W-1:0] out_min_value;
  logic signed [SAMPLE_W-1:0] out_max_value;
  logic [RMS_W-1:0]           out_rms_value;
  logic                       out_last_column;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [TOTAL_W-1:0]         cfg_wdata = '0;

  // bin tracker state
  logic [TOTAL_W-1:0]         cur_total;
  logic [COLS_W-1:0]          cur_cols;
  logic [COL_W-1:0]           col_idx;
  logic [POS_W-1:0]           scaled_pos;
  logic [POS_W-1:0]           scaled_bnd;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic [SUM_W-1:0]           run_sqsum;
  logic                       bin_active;

  bin_result_t pending_bins[$];
  int errors = 0;
  int n_sent = 0;
  int n_live = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_phases = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  waveform_min_max_rms_binner_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_first_of_clip(in_first_of_clip),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_min_value   (out_min_value),
    .out_max_value   (out_max_value),
    .out_rms_value   (out_rms_value),
    .out_last_column (out_last_column),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic bin_reset();
    cur_total = TOTAL_RST;
    cur_cols = COLS_RST;
    col_idx = '0;
    scaled_pos = '0;
    scaled_bnd = POS_W'(TOTAL_RST);
    run_min = '0;
    run_max = '0;
    run_sqsum = '0;
    bin_active = 1'b0;
  endtask

  task automatic bin_step(input logic signed [SAMPLE_W-1:0] x, input logic first,
                          output bit counted, output bit closed, output bin_result_t res);
    longint unsigned t;
    longint unsigned c;
    longint unsigned clip_end;
    longint unsigned nxt;
    longint unsigned q;
    longint unsigned sq;
    longint unsigned root;
    t = (cur_total == '0) ? 64'd1 : 64'(cur_total);
    c = (cur_cols == '0) ? 64'd1 : 64'(cur_cols);
    if (c > 64'(COLS_MAX)) c = 64'(COLS_MAX);
    if (c > t) c = t;
    clip_end = t * c;
    sq = 64'(longint'(x) * longint'(x));
    counted = 1'b0;
    closed = 1'b0;
    res = '0;
    if (first) begin
      col_idx = '0;
      scaled_pos = '0;
      scaled_bnd = POS_W'(t);
      bin_active = 1'b0;
    end
    if (64'(scaled_pos) >= clip_end || 64'(col_idx) >= c) return;
    counted = 1'b1;
    if (!bin_active) begin
      run_min = x;
      run_max = x;
      run_sqsum = SUM_W'(sq);
      bin_active = 1'b1;
    end else begin
      if (x < run_min) run_min = x;
      if (x > run_max) run_max = x;
      run_sqsum = run_sqsum + SUM_W'(sq);
    end
    nxt = (64'(scaled_pos) + c) & POS_MASK;
    if (nxt < 64'(scaled_bnd)) begin
      scaled_pos = POS_W'(nxt);
      return;
    end
    q = 64'(run_sqsum) / t;
    if (q >= RMS_FULL * RMS_FULL) begin
      root = RMS_FULL;
    end else begin
      q = q * c + ((64'(run_sqsum) % t) * c) / t;
      root = int_sqrt(q);
      if (root > RMS_FULL) root = RMS_FULL;
    end
    closed = 1'b1;
    res.column = col_idx;
    res.min_v = run_min;
    res.max_v = run_max;
    res.rms = RMS_W'(root);
    res.last = (64'(col_idx) == c - 64'd1);
    if (res.last) begin
      bin_active = 1'b0;
      scaled_pos = POS_W'(clip_end);
    end else begin
      col_idx = col_idx + 1'b1;
      // boundary sample inside the closed bin opens the next one too
      if (nxt > 64'(scaled_bnd)) begin
        run_min = x;
        run_max = x;
        run_sqsum = SUM_W'(sq);
        bin_active = 1'b1;
      end else begin
        bin_active = 1'b0;
      end
      scaled_bnd = POS_W'(64'(scaled_bnd) + t);
      scaled_pos = POS_W'(nxt);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] i, input logic [TOTAL_W-1:0] d);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = i;
    r.data = d;
    return r;
  endfunction

  function automatic dir_row_t smp_row(input logic signed [SAMPLE_W-1:0] s, input logic f);
    dir_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.sample = s;
    r.first = f;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic signed [SAMPLE_W-1:0] s, input logic f,
                                       input logic [COL_W-1:0] col,
                                       input logic signed [SAMPLE_W-1:0] mn,
                                       input logic signed [SAMPLE_W-1:0] mx,
                                       input logic [RMS_W-1:0] rms, input logic last);
    dir_row_t r;
    r = smp_row(s, f);
    r.typed = 1'b1;
    r.expected = '{col, mn, mx, rms, last};
    return r;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic f,
                             input bit typed, input bin_result_t typed_exp, output bit counted);
    int gap;
    bit closed;
    bin_result_t res;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_first_of_clip <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    bin_step(s, f, counted, closed, res);
    if (typed) pending_bins.push_back(typed_exp);
    else if (closed) pending_bins.push_back(res);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TOTAL_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    // a sample that closes no column may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_TOTAL) cur_total = val;
    else if (idx == REG_COLUMNS) cur_cols = val[COLS_W-1:0];
    n_writes++;
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    end
  endtask

  // result side: compare each transaction, random stalls and one long hold-off
  initial begin
    int stall;
    int hold;
    bin_result_t e;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_bins.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual column %0d",
                   $time, out_column);
        end else begin
          e = pending_bins.pop_front();
          n_checked++;
          check_field("column", longint'(e.column), longint'(out_column));
          check_field("min_value", longint'(e.min_v), longint'(out_min_value));
          check_field("max_value", longint'(e.max_v), longint'(out_max_value));
          check_field("rms_value", longint'(e.rms), longint'(out_rms_value));
          check_field("last_column", longint'(e.last), longint'(out_last_column));
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    bit counted;
    int pick;
    int how;
    int span;
    int n_items;
    bit restart;
    logic f;
    logic [TOTAL_W-1:0] new_total;
    logic [COLS_W-1:0] new_cols;

    bin_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration, no clip start
    rows.push_back(smp_row(16'sd1000, 1'b0));
    rows.push_back(smp_row(-16'sd1000, 1'b0));
    // one sample per clip, full scale both ways
    rows.push_back(cfg_row(REG_TOTAL, 24'd1));
    rows.push_back(cfg_row(REG_COLUMNS, 24'd1));
    rows.push_back(chk_row(16'sh7FFF, 1'b1, 12'd0, 16'sh7FFF, 16'sh7FFF, 16'd32767, 1'b1));
    rows.push_back(chk_row(16'sh8000, 1'b1, 12'd0, 16'sh8000, 16'sh8000, RMS_SAT, 1'b1));
    rows.push_back(smp_row(16'sd5, 1'b0));
    rows.push_back(chk_row(16'sd0, 1'b1, 12'd0, 16'sd0, 16'sd0, 16'd0, 1'b1));
    // zero total and zero columns
    rows.push_back(cfg_row(REG_TOTAL, 24'd0));
    rows.push_back(chk_row(-16'sd1, 1'b1, 12'd0, -16'sd1, -16'sd1, 16'd1, 1'b1));
    rows.push_back(cfg_row(REG_COLUMNS, 24'd0));
    rows.push_back(chk_row(16'sd100, 1'b1, 12'd0, 16'sd100, 16'sd100, 16'd100, 1'b1));
    // column count saturates and clamps to total
    rows.push_back(cfg_row(REG_TOTAL, 24'd2));
    rows.push_back(cfg_row(REG_COLUMNS, 24'h1FFF));
    rows.push_back(chk_row(16'sd10, 1'b1, 12'd0, 16'sd10, 16'sd10, 16'd10, 1'b0));
    rows.push_back(chk_row(-16'sd20, 1'b0, 12'd1, -16'sd20, -16'sd20, 16'd20, 1'b1));
    // fractional width, shared boundary sample
    rows.push_back(cfg_row(REG_TOTAL, 24'd3));
    rows.push_back(cfg_row(REG_COLUMNS, 24'd2));
    rows.push_back(smp_row(16'sd3, 1'b1));
    rows.push_back(smp_row(-16'sd4, 1'b0));
    rows.push_back(smp_row(16'sd7, 1'b0));
    // largest total and column count
    rows.push_back(cfg_row(REG_TOTAL, 24'hFFFFFF));
    rows.push_back(cfg_row(REG_COLUMNS, TOTAL_W'(COLS_MAX)));
    rows.push_back(smp_row(16'sh7FFF, 1'b1));
    rows.push_back(smp_row(16'sh8000, 1'b0));
    rows.push_back(smp_row(16'sh5555, 1'b0));
    rows.push_back(smp_row(16'shAAAA, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
      else send_sample(rows[i].sample, rows[i].first, rows[i].typed, rows[i].expected, counted);
    end

    while (n_live < RAND_ITEMS) begin
      n_phases++;
      pick = $urandom_range(0, 11);
      case (pick)
        0: begin
          new_total = TOTAL_W'($urandom_range(600, 1200));
          new_cols = COLS_MAX;
        end
        1: begin
          new_total = 24'hFFFFFF;
          new_cols = COLS_W'($urandom_range(1, 4096));
        end
        2: begin
          new_total = '0;
          new_cols = COLS_W'($urandom_range(0, 8191));
        end
        3: begin
          new_total = TOTAL_W'($urandom_range(1, 40));
          new_cols = ($urandom_range(0, 1) != 0) ? 13'h1FFF : 13'd0;
        end
        default: begin
          new_total = TOTAL_W'($urandom_range(1, 48));
          new_cols = COLS_W'($urandom_range(1, 52));
        end
      endcase
      how = $urandom_range(0, 9);
      if (how != 0 && how != 2) write_reg(REG_TOTAL, new_total);
      if (how != 0 && how != 1) write_reg(REG_COLUMNS, TOTAL_W'(new_cols));
      restart = ($urandom_range(0, 6) != 0);
      span = (cur_total == '0) ? 1 : ((cur_total > MAX_SPAN) ? MAX_SPAN : int'(cur_total));
      if (!hold_req && restart && cur_total <= 24'd48) hold_req = 1'b1;
      n_items = span + $urandom_range(0, 3);
      for (int i = 0; i < n_items; i++) begin
        f = (i == 0) ? restart : ($urandom_range(0, 80) == 0);
        send_sample(rand_sample(), f, 1'b0, '0, counted);
        if (counted) n_live++;
        if (n_live >= RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d samples (%0d binned), %0d register writes, %0d random phases",
             n_sent, n_live, n_writes, n_phases);
    $display("%0d column transactions compared, long output hold-off %s",
             n_checked, hold_done ? "applied" : "not applied");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/wmb_pkg.sv
sv/wmb_rms_unit.sv
sv/waveform_min_max_rms_binner_top.sv
verif/waveform_min_max_rms_binner_top_tb.sv
